>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/btc_pkg.sv
`timescale 1ns / 1ps

package btc_pkg;

    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam int unsigned COUNT_BITS     = 8;
    localparam int unsigned DUR_BITS       = 32;
    localparam int unsigned STAMP_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_INTERVAL  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_INTERVAL = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] HOLD_INTERVAL_RESET  = 32'd1000000;
    localparam logic [CFG_DATA_BITS-1:0] COUNT_INTERVAL_RESET = 32'd200000;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'hFF;

    localparam logic [COUNT_BITS-1:0] COUNT_NONE   = 8'd0;
    localparam logic [COUNT_BITS-1:0] COUNT_SINGLE = 8'd1;
    localparam logic [COUNT_BITS-1:0] COUNT_DOUBLE = 8'd2;
    localparam logic [COUNT_BITS-1:0] COUNT_TRIPLE = 8'd3;

    localparam logic [2:0] TAP_NONE   = 3'b000;
    localparam logic [2:0] TAP_SINGLE = 3'b001;
    localparam logic [2:0] TAP_DOUBLE = 3'b010;
    localparam logic [2:0] TAP_TRIPLE = 3'b100;

    typedef struct packed {
        logic                  button_level;
        logic [STAMP_BITS-1:0] now_us;
    } t_in_word;

    typedef struct packed {
        logic                  level_seen;
        logic                  pressed;
        logic                  hold_flag;
        logic [COUNT_BITS-1:0] tap_count;
        logic                  single_tap;
        logic                  double_tap;
        logic                  triple_tap;
        logic [DUR_BITS-1:0]   press_duration;
    } t_out_word;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] hold_interval;
        logic [CFG_DATA_BITS-1:0] count_interval;
    } t_cfg;

endpackage

>>> hw/rtl/btc_in_reg.sv
`timescale 1ns / 1ps

module btc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  btc_pkg::t_in_word i_word,
    input  logic              i_advance,
    output logic              o_valid,
    output btc_pkg::t_in_word o_word
);

    logic              r_valid;
    logic              n_valid;
    btc_pkg::t_in_word r_word;
    logic              w_load;

    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;
    assign n_valid = w_load || (r_valid && !i_advance);
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= i_word;
        end
    end

endmodule

>>> hw/rtl/btc_core.sv
`timescale 1ns / 1ps

module btc_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  btc_pkg::t_in_word  i_word,
    input  btc_pkg::t_cfg      i_cfg,
    output btc_pkg::t_out_word o_result
);

    localparam int unsigned CMP_BITS =
        (TIME_BITS > btc_pkg::CFG_DATA_BITS) ? TIME_BITS : btc_pkg::CFG_DATA_BITS;
    localparam int unsigned EXT_BITS = TIME_BITS + btc_pkg::STAMP_BITS;

    logic                           r_pressed;
    logic                           r_hold;
    logic [TIME_BITS-1:0]           r_mark;
    logic [btc_pkg::COUNT_BITS-1:0] r_count;
    logic [2:0]                     r_flags;
    logic [btc_pkg::DUR_BITS-1:0]   r_dur;

    logic                           n_pressed;
    logic                           n_hold;
    logic [TIME_BITS-1:0]           n_mark;
    logic [btc_pkg::COUNT_BITS-1:0] n_count;
    logic [btc_pkg::COUNT_BITS-1:0] w_count_upd;
    logic [2:0]                     n_flags;
    logic [btc_pkg::DUR_BITS-1:0]   n_dur;

    logic [EXT_BITS-1:0]  w_now_ext;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_elapsed;
    logic [CMP_BITS-1:0]  w_el_wide;
    logic                 w_over_hold;
    logic                 w_over_count;
    logic                 w_tap_release;
    logic                 w_idle;

    assign w_now_ext    = {{TIME_BITS{1'b0}}, i_word.now_us};
    assign w_now        = w_now_ext[TIME_BITS-1:0];
    assign w_elapsed    = w_now - r_mark;
    assign w_el_wide    = CMP_BITS'(w_elapsed);
    assign w_over_hold  = w_el_wide > CMP_BITS'(i_cfg.hold_interval);
    assign w_over_count = w_el_wide > CMP_BITS'(i_cfg.count_interval);

    always_comb begin
        n_pressed     = r_pressed;
        n_hold        = r_hold;
        n_mark        = r_mark;
        w_count_upd   = r_count;
        n_dur         = r_dur;
        n_flags       = r_flags;
        w_tap_release = 1'b0;

        if (i_word.button_level) begin
            if (!r_pressed) begin
                n_pressed = 1'b1;
                n_mark    = w_now;
            end else if (w_over_hold) begin
                n_hold = 1'b1;
            end
        end else if (r_hold) begin
            n_hold      = 1'b0;
            n_pressed   = 1'b0;
            w_count_upd = btc_pkg::COUNT_NONE;
        end else if (r_pressed) begin
            w_tap_release = 1'b1;
            n_pressed     = 1'b0;
            n_dur         = w_el_wide[btc_pkg::DUR_BITS-1:0];
            n_mark        = w_now;
            if (r_count != btc_pkg::COUNT_MAX) begin
                w_count_upd = r_count + btc_pkg::COUNT_BITS'(1);
            end
        end

        // A fresh mark measures zero elapsed time, so only an untouched mark can expire.
        w_idle  = !n_pressed && !w_tap_release && w_over_count;
        n_count = w_count_upd;
        if (w_idle) begin
            case (w_count_upd)
                btc_pkg::COUNT_NONE:   n_flags = btc_pkg::TAP_NONE;
                btc_pkg::COUNT_SINGLE: n_flags = btc_pkg::TAP_SINGLE;
                btc_pkg::COUNT_DOUBLE: n_flags = btc_pkg::TAP_DOUBLE;
                btc_pkg::COUNT_TRIPLE: n_flags = btc_pkg::TAP_TRIPLE;
                default:               n_flags = r_flags;
            endcase
            n_count = btc_pkg::COUNT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_hold    <= 1'b0;
            r_mark    <= '0;
            r_count   <= '0;
            r_flags   <= '0;
            r_dur     <= '0;
        end else if (i_fire) begin
            r_pressed <= n_pressed;
            r_hold    <= n_hold;
            r_mark    <= n_mark;
            r_count   <= n_count;
            r_flags   <= n_flags;
            r_dur     <= n_dur;
        end
    end

    always_comb begin
        o_result.level_seen     = i_word.button_level;
        o_result.pressed        = n_pressed;
        o_result.hold_flag      = n_hold;
        o_result.tap_count      = n_count;
        o_result.single_tap     = n_flags[0];
        o_result.double_tap     = n_flags[1];
        o_result.triple_tap     = n_flags[2];
        o_result.press_duration = n_dur;
    end

endmodule

>>> hw/rtl/button_tap_hold_classifier.sv
`timescale 1ns / 1ps
// A word accepted into the input register has its result registered in the result
// register. Throughput: one word per cycle while the output is not stalled; the input
// register and the result register each advance whenever the next stage is free,
// so stalls cost no bubbles. Reset clears all press, tap and duration state, empties
// both registers and restores the interval registers to their default values.

`include "assert_macros.svh"

module button_tap_hold_classifier #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  btc_pkg::t_in_word                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output btc_pkg::t_out_word                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [btc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [btc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    btc_pkg::t_cfg      r_cfg;
    btc_pkg::t_out_word r_out;
    btc_pkg::t_out_word w_result;
    btc_pkg::t_in_word  w_stage_word;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_stage_valid;
    logic               w_fire;
    logic [2:0]         w_tap_flags;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_interval  <= btc_pkg::HOLD_INTERVAL_RESET;
            r_cfg.count_interval <= btc_pkg::COUNT_INTERVAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                btc_pkg::REG_HOLD_INTERVAL:  r_cfg.hold_interval  <= i_cfg_data;
                btc_pkg::REG_COUNT_INTERVAL: r_cfg.count_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_fire = w_stage_valid && (!r_out_valid || !i_out_stall);

    btc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_word    (i_in),
        .i_advance (w_fire),
        .o_valid   (w_stage_valid),
        .o_word    (w_stage_word)
    );

    btc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_word   (w_stage_word),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    assign n_out_valid = w_fire || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_tap_flags = {r_out.triple_tap, r_out.double_tap, r_out.single_tap};

    `ASSERT_IMPLY(a_hold_needs_press, i_clk, i_rst_n, r_out_valid && r_out.hold_flag, r_out.pressed)
    `ASSERT_IMPLY(a_one_tap_class, i_clk, i_rst_n, r_out_valid, $onehot0(w_tap_flags))
    `ASSERT_NEXT(a_free_slot_fills, i_clk, i_rst_n, w_stage_valid && !r_out_valid, r_out_valid)

endmodule

>>> bench/tb_button_tap_hold_classifier.sv
`timescale 1ns / 1ps

module tb_button_tap_hold_classifier;

    localparam int unsigned CYCLE_LIMIT = 200000;

    class tap_scoreboard;
        logic [btc_pkg::CFG_DATA_BITS-1:0] hold_iv;
        logic [btc_pkg::CFG_DATA_BITS-1:0] count_iv;
        logic                              level_q;
        logic                              pressed_q;
        logic                              hold_q;
        logic [btc_pkg::STAMP_BITS-1:0]    mark_q;
        logic [btc_pkg::COUNT_BITS-1:0]    count_q;
        logic [2:0]                        flags_q;
        logic [btc_pkg::DUR_BITS-1:0]      dur_q;
        btc_pkg::t_out_word                expected_q[$];
        int unsigned                       checked;
        int unsigned                       failures;

        function void reset_state();
            hold_iv   = btc_pkg::HOLD_INTERVAL_RESET;
            count_iv  = btc_pkg::COUNT_INTERVAL_RESET;
            level_q   = 1'b0;
            pressed_q = 1'b0;
            hold_q    = 1'b0;
            mark_q    = '0;
            count_q   = btc_pkg::COUNT_NONE;
            flags_q   = btc_pkg::TAP_NONE;
            dur_q     = '0;
            expected_q.delete();
            checked   = 0;
            failures  = 0;
        endfunction

        function void set_reg(logic [btc_pkg::CFG_INDEX_BITS-1:0] idx,
                              logic [btc_pkg::CFG_DATA_BITS-1:0] value);
            if (idx == btc_pkg::REG_HOLD_INTERVAL) begin
                hold_iv = value;
            end else if (idx == btc_pkg::REG_COUNT_INTERVAL) begin
                count_iv = value;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function string fmt_word(btc_pkg::t_out_word w);
            return $sformatf({"level %b pressed %b hold %b count %0d ",
                              "taps s%b d%b t%b duration %0d"},
                             w.level_seen, w.pressed, w.hold_flag, w.tap_count,
                             w.single_tap, w.double_tap, w.triple_tap, w.press_duration);
        endfunction

        function void note_input(btc_pkg::t_in_word w);
            logic [btc_pkg::STAMP_BITS-1:0] since;
            btc_pkg::t_out_word             want;
            level_q = w.button_level;
            if (w.button_level) begin
                if (!pressed_q) begin
                    pressed_q = 1'b1;
                    mark_q    = w.now_us;
                end
                since = w.now_us - mark_q;
                if (since > hold_iv) begin
                    hold_q = 1'b1;
                end
            end else if (hold_q) begin
                hold_q    = 1'b0;
                pressed_q = 1'b0;
                count_q   = btc_pkg::COUNT_NONE;
            end else if (pressed_q) begin
                pressed_q = 1'b0;
                dur_q     = w.now_us - mark_q;
                mark_q    = w.now_us;
                if (count_q != btc_pkg::COUNT_MAX) begin
                    count_q = count_q + btc_pkg::COUNT_BITS'(1);
                end
            end
            since = w.now_us - mark_q;
            if (!pressed_q && since > count_iv) begin
                case (count_q)
                    btc_pkg::COUNT_NONE:   flags_q = btc_pkg::TAP_NONE;
                    btc_pkg::COUNT_SINGLE: flags_q = btc_pkg::TAP_SINGLE;
                    btc_pkg::COUNT_DOUBLE: flags_q = btc_pkg::TAP_DOUBLE;
                    btc_pkg::COUNT_TRIPLE: flags_q = btc_pkg::TAP_TRIPLE;
                    default: ;
                endcase
                count_q = btc_pkg::COUNT_NONE;
            end
            want.level_seen     = level_q;
            want.pressed        = pressed_q;
            want.hold_flag      = hold_q;
            want.tap_count      = count_q;
            want.single_tap     = |(flags_q & btc_pkg::TAP_SINGLE);
            want.double_tap     = |(flags_q & btc_pkg::TAP_DOUBLE);
            want.triple_tap     = |(flags_q & btc_pkg::TAP_TRIPLE);
            want.press_duration = dur_q;
            expected_q.push_back(want);
        endfunction

        function void check_result(btc_pkg::t_out_word got);
            btc_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("Unexpected result word: %s", fmt_word(got));
                end
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("Mismatch on result word %0d", checked);
                    $display("  expected %s", fmt_word(want));
                    $display("  actual   %s", fmt_word(got));
                end
            end
        endfunction
    endclass

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_stall;
    btc_pkg::t_in_word                  i_in        = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    btc_pkg::t_out_word                 o_out;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [btc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = btc_pkg::REG_HOLD_INTERVAL;
    logic [btc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    tap_scoreboard                  sb;
    logic [btc_pkg::STAMP_BITS-1:0] stamp      = '0;
    int unsigned                    send_idle  = 26;
    int unsigned                    recv_idle  = 71;
    int unsigned                    words_sent = 0;
    int unsigned                    cycles     = 0;

    button_tap_hold_classifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out);
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [btc_pkg::STAMP_BITS-1:0] short_step(
            logic [btc_pkg::CFG_DATA_BITS-1:0] iv);
        if (iv < 4) begin
            return $urandom_range(0, iv);
        end
        return $urandom_range(0, iv / 4);
    endfunction

    function automatic logic [btc_pkg::STAMP_BITS-1:0] near_step(
            logic [btc_pkg::CFG_DATA_BITS-1:0] iv);
        case ($urandom_range(6))
            0: return iv;
            1: return iv + btc_pkg::CFG_DATA_BITS'(1);
            2: return iv - btc_pkg::CFG_DATA_BITS'(1);
            3: return $urandom_range(0, 50);
            4: return iv + $urandom_range(2, 500);
            5: return $urandom;
            default: return iv / 2;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send(input logic level);
        btc_pkg::t_in_word w;
        w.button_level = level;
        w.now_us       = stamp;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [btc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [btc_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic play_random(input int unsigned budget);
        int unsigned                    start;
        int unsigned                    pick;
        int unsigned                    taps;
        logic [btc_pkg::STAMP_BITS-1:0] press_start;
        start = words_sent;
        while (words_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                taps = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
                repeat (taps) begin
                    stamp += short_step(sb.count_iv);
                    send(1'b1);
                    repeat ($urandom_range(0, 2)) begin
                        stamp += short_step(sb.hold_iv);
                        send(1'b1);
                    end
                    stamp += short_step(sb.hold_iv);
                    send(1'b0);
                    repeat ($urandom_range(0, 1)) begin
                        stamp += short_step(sb.count_iv);
                        send(1'b0);
                    end
                end
                stamp += near_step(sb.count_iv);
                send(1'b0);
            end else if (pick < 65) begin
                stamp += short_step(sb.count_iv);
                press_start = stamp;
                send(1'b1);
                repeat ($urandom_range(1, 3)) begin
                    stamp = press_start + near_step(sb.hold_iv);
                    send(1'b1);
                end
                stamp += ($urandom_range(1)) ? short_step(sb.count_iv) : near_step(sb.count_iv);
                send(1'b0);
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 3)) begin
                    stamp += near_step(sb.count_iv);
                    send(1'b0);
                end
            end else begin
                stamp = ($urandom_range(1)) ? $urandom : stamp + $urandom_range(0, 1000);
                send(1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        logic [btc_pkg::CFG_DATA_BITS-1:0] hold_set;
        logic [btc_pkg::CFG_DATA_BITS-1:0] count_set;
        int                                k;

        sb = new;
        sb.reset_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words under the reset intervals.
        stamp = 32'd0;
        send(1'b0);
        stamp = 32'd100;
        send(1'b1);
        stamp = 32'd1000100;
        send(1'b1);
        stamp = 32'd1000101;
        send(1'b1);
        // Release after a hold: the idle check measures from the press start.
        stamp = 32'd2000000;
        send(1'b0);
        stamp = 32'd3000000;
        send(1'b1);
        stamp = 32'd3000050;
        send(1'b0);
        stamp = 32'd3200050;
        send(1'b0);
        stamp = 32'd3200051;
        send(1'b0);
        for (k = 2; k <= 3; k++) begin
            stamp = k * 32'd1000000 + 32'd2000000;
            repeat (k) begin
                stamp += 32'd10;
                send(1'b1);
                stamp += 32'd20;
                send(1'b0);
            end
            stamp += 32'd300000;
            send(1'b0);
        end
        // A press that spans the wrap of the time stamp.
        stamp = 32'hFFFF_FFF0;
        send(1'b1);
        stamp = 32'h0000_0010;
        send(1'b0);
        stamp = 32'hFFFF_FFFF;
        send(1'b0);

        for (k = 0; k < 6; k++) begin
            drain();
            if (k == 2) begin
                send_idle = 71;
                recv_idle = 26;
            end else if (k == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (k)
                0: begin
                    hold_set  = 32'd40;
                    count_set = 32'd25;
                end
                1: begin
                    hold_set  = '0;
                    count_set = '0;
                end
                2: begin
                    hold_set  = '1;
                    count_set = '1;
                end
                3: begin
                    hold_set  = $urandom_range(100, 5000);
                    count_set = $urandom_range(50, 2000);
                end
                4: begin
                    hold_set  = $urandom;
                    count_set = $urandom;
                end
                default: begin
                    hold_set  = btc_pkg::HOLD_INTERVAL_RESET;
                    count_set = btc_pkg::COUNT_INTERVAL_RESET;
                end
            endcase
            write_reg(btc_pkg::REG_HOLD_INTERVAL, hold_set);
            write_reg(btc_pkg::REG_COUNT_INTERVAL, count_set);
            if (k == 2) begin
                // With the widest idle interval the count never clears and must saturate.
                repeat (260) begin
                    stamp += 32'd3;
                    send(1'b1);
                    stamp += 32'd2;
                    send(1'b0);
                end
            end
            play_random(130);
        end

        drain();
        repeat (10) @(negedge i_clk);
        $display("Checked %0d result words against %0d input words over six interval settings,",
                 sb.checked, words_sent);
        $display("including holds, multi-tap sequences, count saturation and stamp wrap.");
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures, %0d result words still expected.", sb.failures, sb.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/btc_pkg.sv
hw/rtl/btc_in_reg.sv
hw/rtl/btc_core.sv
hw/rtl/button_tap_hold_classifier.sv
bench/tb_button_tap_hold_classifier.sv
